@@ rtl/swpec_pkg.sv @@
// ----------------------------------------------------------------------------
// swpec_pkg
// shared widths and field layout for the sliding window peak event counter
// ----------------------------------------------------------------------------
package swpec_pkg;

   localparam int TIME_W      = 32;
   localparam int COUNT_OUT_W = 11;
   localparam int RSP_FIELD_W = 2 * COUNT_OUT_W + 2 * TIME_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   typedef logic [TIME_W-1:0]      time_type;
   typedef logic [COUNT_OUT_W-1:0] count_out_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      count_out_type        current_count;
      time_type             best_last_time;
      time_type             best_first_time;
      count_out_type        best_count;
   } rsp_data_type;

endpackage

@@ rtl/swpec_time_ram.sv @@
// ----------------------------------------------------------------------------
// swpec_time_ram
// timestamp store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module swpec_time_ram #(
   parameter int DEPTH = 1024,
   parameter int IW    = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  logic [swpec_pkg::TIME_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IW-1:0]            rd_addr,
   output logic [swpec_pkg::TIME_W-1:0] rd_data
);
   import swpec_pkg::*;

   time_type mem [DEPTH];
   time_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/swpec_span_cmp.sv @@
// ----------------------------------------------------------------------------
// swpec_span_cmp
// span check: saturating difference of new and oldest time against the window
// ----------------------------------------------------------------------------
module swpec_span_cmp (
   input  logic [swpec_pkg::TIME_W-1:0] new_time,
   input  logic [swpec_pkg::TIME_W-1:0] oldest_time,
   input  logic [swpec_pkg::TIME_W-1:0] window,
   output logic                         exceeds
);
   import swpec_pkg::*;

   logic [TIME_W:0] diff;

   assign diff    = {1'b0, new_time} - {1'b0, oldest_time};
   assign exceeds = !diff[TIME_W] && (diff[TIME_W-1:0] > window);

endmodule

@@ rtl/sliding_window_peak_event_count.sv @@
// ----------------------------------------------------------------------------
// sliding_window_peak_event_count
// sliding window event counter that tracks the busiest window seen so far
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one timestamp word per event (seconds, nondecreasing).
//   rsp_ returns one word per event: best count, first and last time of the
//   best window, current window count, and an overflow flag in tuser.
//   csr_wr_en writes window_seconds; write it only while the block is idle.
// sequence:
//   an event is accepted in S_IDLE and checked in S_CHECK, which registers
//   its result word once the output register is free; no new event is
//   taken until S_IDLE. each evicted entry adds a timestamp ram read for the
//   new oldest entry and an S_LOAD pass into the span compare unit; an
//   emptying eviction skips both. a full store costs one more eviction.
// reset:
//   synchronous, clears counts, pointers and the best window; the ram holds
//   no valid state and needs no clearing pass.
// stall:
//   the result sits in an output register; the next event is accepted while
//   it waits, and its result is held back until the register frees up.
// ----------------------------------------------------------------------------
module sliding_window_peak_event_count #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [swpec_pkg::TIME_W-1:0]        csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [swpec_pkg::TIME_W-1:0]        req_tdata,  // timestamp
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // best_count, best_first_time, best_last_time, current_count, zero pad
   output logic [swpec_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser   // overflow
);
   import swpec_pkg::*;

   localparam int IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_LOAD  = 2'd2;

   localparam logic [IW-1:0] LAST_SLOT  = IW'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   time_type      oldest_ff, oldest_in;
   logic [CW-1:0] peak_count_ff, peak_count_in;
   time_type      peak_first_ff, peak_first_in;
   time_type      peak_last_ff, peak_last_in;
   time_type      window_ff;
   logic          ovf_ff, ovf_in;
   time_type      t_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          exceeds;
   logic          out_free;
   logic [IW-1:0] head_next;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] count_inc;
   logic          wr_en, rd_en;
   time_type      rd_data;
   logic [31:0]   cur_wide, peak_wide;

   swpec_span_cmp u_span (
      .new_time    (t_ff),
      .oldest_time (oldest_ff),
      .window      (window_ff),
      .exceeds     (exceeds)
   );

   swpec_time_ram #(
      .DEPTH (FIFO_DEPTH),
      .IW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (t_ff),
      .rd_en   (rd_en),
      .rd_addr (head_next),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign head_next  = (head_ff == LAST_SLOT) ? '0 : head_ff + IW'(1);
   assign count_dec  = count_ff - CW'(1);
   assign count_inc  = count_ff + CW'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      oldest_in     = oldest_ff;
      peak_count_in = peak_count_ff;
      peak_first_in = peak_first_ff;
      peak_last_in  = peak_last_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      cur_wide      = 32'(count_inc);
      peak_wide     = 32'(peak_count_ff);
      case (state_ff)
         S_IDLE: begin
            ovf_in = 1'b0;
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!ovf_ff && ((count_ff != '0 && exceeds) || count_ff == FULL_COUNT)) begin
               // drop the oldest entry
               head_in  = head_next;
               count_in = count_dec;
               if (!(count_ff != '0 && exceeds)) begin
                  ovf_in = 1'b1;
               end
               if (count_dec != '0) begin
                  rd_en    = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  oldest_in = t_ff;
               end
            end else if (out_free) begin
               wr_en    = 1'b1;
               tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + IW'(1);
               count_in = count_inc;
               if (count_ff == '0) begin
                  oldest_in = t_ff;
               end
               if (count_inc > peak_count_ff) begin
                  peak_count_in = count_inc;
                  peak_first_in = (count_ff == '0) ? t_ff : oldest_ff;
                  peak_last_in  = t_ff;
                  peak_wide     = 32'(count_inc);
               end
               rsp_valid_in                = 1'b1;
               rsp_data_in.pad             = '0;
               rsp_data_in.best_count      = peak_wide[COUNT_OUT_W-1:0];
               rsp_data_in.best_first_time = peak_first_in;
               rsp_data_in.best_last_time  = peak_last_in;
               rsp_data_in.current_count   = cur_wide[COUNT_OUT_W-1:0];
               rsp_ovf_in                  = ovf_ff;
               state_in                    = S_IDLE;
            end
         end
         S_LOAD: begin
            oldest_in = rd_data;
            state_in  = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         oldest_ff     <= '0;
         peak_count_ff <= '0;
         peak_first_ff <= '0;
         peak_last_ff  <= '0;
         window_ff     <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         oldest_ff     <= oldest_in;
         peak_count_ff <= peak_count_in;
         peak_first_ff <= peak_first_in;
         peak_last_ff  <= peak_last_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         t_ff <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

@@ tb/tb_sliding_window_peak_event_count.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_peak_event_count
// self-checking bench for the sliding window peak event counter
// ----------------------------------------------------------------------------
// A short table of directed words covers the first event, wide and narrow
// windows, timestamps that step back below the oldest held one, and a window
// emptied by eviction. Random phases follow at several window settings. The
// phase at the widest window holds more events than the store can keep, so
// the store overflows. Each accepted word goes through a behavioral tracker,
// and every result word is compared field by field with the oldest predicted
// report. Both sides idle at random. The receiver also holds off for a long
// stretch, and the sender drains all results before each window change.
// ----------------------------------------------------------------------------
module tb_sliding_window_peak_event_count;
   timeunit 1ns;
   timeprecision 1ps;

   import swpec_pkg::*;

   localparam int DEPTH           = 1024;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int IDLE_PCT        = 23;
   localparam int NOISE_PCT       = 4;

   typedef struct packed {
      logic          overflow;
      count_out_type current_count;
      time_type      best_last_time;
      time_type      best_first_time;
      count_out_type best_count;
   } peak_report_t;

   typedef struct packed {
      bit           is_cfg;
      bit           typed;
      time_type     value;
      peak_report_t want;
   } stim_row_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [TIME_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [TIME_W-1:0]     req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // best_count, best_first_time, best_last_time,
                                       // current_count, zero pad
   logic                  rsp_tuser;   // overflow

   // tracker state
   time_type     window_span = '0;
   time_type     ring_time [DEPTH];
   int           ring_head    = 0;
   int           ring_tail    = 0;
   int           in_window    = 0;
   time_type     win_oldest   = '0;
   time_type     win_newest   = '0;
   int           peak_cnt     = 0;
   time_type     peak_first_t = '0;
   time_type     peak_last_t  = '0;
   bit           seen_first   = 1'b0;

   peak_report_t report_q [$];
   stim_row_t    dir_rows [$];
   int           errors   = 0;
   bit           tx_quiet = 1'b0;
   bit           rx_quiet = 1'b0;
   bit           hold_rsp = 1'b0;
   time_type     now_t    = '0;

   sliding_window_peak_event_count #(
      .FIFO_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void drop_oldest(input time_type ts);
      ring_head = (ring_head + 1) % DEPTH;
      in_window--;
      win_oldest = (in_window > 0) ? ring_time[ring_head] : ts;
   endfunction

   function automatic peak_report_t track_event(input time_type ts);
      peak_report_t rep;
      rep.overflow = 1'b0;
      if (!seen_first) begin
         seen_first = 1'b1;
         ring_head  = 0;
         ring_tail  = 0;
         in_window  = 0;
      end else begin
         // a timestamp below the oldest held counts as zero span
         while (in_window > 0 && ts > win_oldest && (ts - win_oldest) > window_span)
            drop_oldest(ts);
         if (in_window >= DEPTH) begin
            drop_oldest(ts);
            rep.overflow = 1'b1;
         end
      end
      ring_time[ring_tail] = ts;
      ring_tail = (ring_tail + 1) % DEPTH;
      if (in_window == 0)
         win_oldest = ts;
      in_window++;
      win_newest = ts;
      if (in_window > peak_cnt) begin
         peak_cnt     = in_window;
         peak_first_t = win_oldest;
         peak_last_t  = win_newest;
      end
      rep.best_count      = count_out_type'(peak_cnt);
      rep.best_first_time = peak_first_t;
      rep.best_last_time  = peak_last_t;
      rep.current_count   = count_out_type'(in_window);
      return rep;
   endfunction

   function automatic stim_row_t cfg_row(input time_type v);
      stim_row_t r;
      r        = '0;
      r.is_cfg = 1'b1;
      r.value  = v;
      return r;
   endfunction

   function automatic stim_row_t item_row(input time_type ts);
      stim_row_t r;
      r       = '0;
      r.value = ts;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      peak_report_t want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (report_q.size() == 0) begin
            errors++;
            $display("%0t ns unexpected word: expected none, actual %0h / %0h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = report_q.pop_front();
            check_field("best_count", 32'(want.best_count), 32'(got.best_count));
            check_field("best_first_time", want.best_first_time, got.best_first_time);
            check_field("best_last_time", want.best_last_time, got.best_last_time);
            check_field("current_count", 32'(want.current_count), 32'(got.current_count));
            check_field("overflow", 32'(want.overflow), 32'(rsp_tuser));
            check_field("pad", 32'h0, 32'(got.pad));
         end
      end
   end

   // receiver: random back pressure, quiet stretches and long holds
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= rx_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic send_stamp(input time_type ts, input bit typed, input peak_report_t want);
      int           gap;
      peak_report_t got;
      gap = 0;
      if (!tx_quiet)
         while ($urandom_range(0, 99) < IDLE_PCT)
            gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ts;
      do @(posedge clock); while (!req_tready);
      got = track_event(ts);
      report_q.push_back(typed ? want : got);
   endtask

   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (report_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_window(input time_type v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      window_span = v;
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input time_type span, input int n_items,
                            input int unsigned max_step, input bit quiet, input bit hold);
      time_type ts;
      drain_reports();
      write_window(span);
      tx_quiet = quiet;
      rx_quiet = quiet;
      now_t    = $urandom;
      for (int i = 0; i < n_items; i++) begin
         if (hold && i == 10)
            hold_rsp = 1'b1;
         if ($urandom_range(0, 99) < NOISE_PCT) begin
            ts = $urandom;
         end else begin
            now_t = now_t + $urandom_range(0, max_step);
            ts    = now_t;
         end
         send_stamp(ts, 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_t r;
      // first event after reset, window still at its reset value of zero
      r = item_row(32'h0);
      r.typed = 1'b1;
      r.want  = '{overflow: 1'b0, current_count: 11'd1, best_last_time: 32'h0,
                  best_first_time: 32'h0, best_count: 11'd1};
      dir_rows.push_back(r);
      dir_rows.push_back(item_row(32'h0));
      dir_rows.push_back(item_row(32'h5));           // empties the window
      dir_rows.push_back(item_row(32'h3));           // below oldest, tie on best
      dir_rows.push_back(cfg_row(32'hFFFF_FFFF));
      dir_rows.push_back(item_row(32'hFFFF_FFFF));
      dir_rows.push_back(item_row(32'hFFFF_FFFF));
      dir_rows.push_back(item_row(32'h0));
      dir_rows.push_back(cfg_row(32'h1));
      dir_rows.push_back(item_row(32'hA));
      dir_rows.push_back(item_row(32'hB));
      dir_rows.push_back(item_row(32'hC));
      dir_rows.push_back(item_row(32'hC));
      dir_rows.push_back(item_row(32'hE));
      dir_rows.push_back(cfg_row(32'h8000_0000));
      dir_rows.push_back(item_row(32'h7FFF_FFFF));
      dir_rows.push_back(item_row(32'hFFFF_FFFF));
      dir_rows.push_back(item_row(32'hFFFF_FFFF));
      dir_rows.push_back(cfg_row(32'h0));
      dir_rows.push_back(item_row(32'hFFFF_FFFF));
      dir_rows.push_back(item_row(32'hFFFF_FFFF));
      dir_rows.push_back(item_row(32'h0));
      dir_rows.push_back(item_row(32'h5555_5555));
      dir_rows.push_back(item_row(32'hAAAA_AAAA));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            drain_reports();
            write_window(dir_rows[i].value);
         end else begin
            send_stamp(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      run_phase(32'h0, 30, 2, 1'b0, 1'b0);
      run_phase(32'h3, 30, 3, 1'b0, 1'b1);
      run_phase(time_type'($urandom_range(4, 40)), 30, 7, 1'b1, 1'b0);
      run_phase(time_type'($urandom), 30, 32'h0FFF_FFFF, 1'b0, 1'b0);
      run_phase(32'hFFFF_FFFF, 1030, 1, 1'b0, 1'b1);   // store overflows
      run_phase(32'h0, 20, 2, 1'b0, 1'b0);

      drain_reports();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
